[hdl/base64_stream_decoder_assert.svh]
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define B64D_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("b64d assertion failed");
`define B64D_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("b64d assertion failed");
`else
`define B64D_ASSERT(name, prop)
`define B64D_ASSERT_ALWAYS(name, prop)
`endif

`endif

[hdl/b64d_pkg.sv]
// shared types for the base64 stream decoder
`timescale 1ns / 1ps
package b64d_pkg;

  localparam int unsigned MaxWords = 3;

  // one decoded job: up to three result words from one character
  typedef struct packed {
    logic [MaxWords-1:0][7:0] data;
    logic [1:0]               words;    // number of words, 1 to 3
    logic                     no_data;
    logic                     msg_end;
  } job_t;

endpackage

[hdl/base64_stream_decoder.sv]
// top level of the base64 stream decoder
`timescale 1ns / 1ps
// Streaming base64 decoder, one ASCII character per word on the input side.
// The front end takes a character in every cycle in which the job queue has
// room; each character yields zero to three decoded bytes, and the message
// end always yields a word with message_end set (no_data when no byte is
// left). The output side sends one word per cycle while out_ready_i is high,
// so a full group of four characters yields three output words; the rate is
// set by the output port and the FifoDepth-entry job queue absorbs the
// bursts. The first result word of a character passes through the job queue
// and then the output sequencer's job register before it becomes valid.
module base64_stream_decoder #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       message_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       no_data_o,
  output logic       run_last_o,
  output logic       message_end_o
);
  import b64d_pkg::*;

  logic push, full, pop, head_valid;
  job_t push_job, head_job;

  b64d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .message_last_i (message_last_i),
    .full_i         (full),
    .push_o         (push),
    .push_job_o     (push_job)
  );

  b64d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .no_data_o     (no_data_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule

[hdl/b64d_front.sv]
// front end: accepts characters, decodes sextets and builds result jobs
`timescale 1ns / 1ps
`include "base64_stream_decoder_assert.svh"
module b64d_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     char_code_i,
  input  logic           message_last_i,
  input  logic           full_i,
  output logic           push_o,
  output b64d_pkg::job_t push_job_o
);
  import b64d_pkg::*;

  localparam logic [7:0] UpperA = 8'h41;
  localparam logic [7:0] UpperZ = 8'h5a;
  localparam logic [7:0] LowerA = 8'h61;
  localparam logic [7:0] LowerZ = 8'h7a;
  localparam logic [7:0] Digit0 = 8'h30;
  localparam logic [7:0] Digit9 = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharSlash = 8'h2f;

  logic [2:0][5:0] buf_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            stopped_q, stopped_d;

  logic            accept;
  logic            is_alpha;
  logic [5:0]      sextet;
  logic            full_grp, take_new, do_flush, have_bytes;
  logic [2:0][5:0] ebuf;
  logic [1:0]      ecnt;
  job_t            job;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // alphabet lookup
  always_comb begin
    is_alpha = 1'b1;
    sextet   = '0;
    if (char_code_i >= UpperA && char_code_i <= UpperZ) begin
      sextet = 6'(char_code_i - UpperA);
    end else if (char_code_i >= LowerA && char_code_i <= LowerZ) begin
      sextet = 6'(char_code_i - 8'h47);
    end else if (char_code_i >= Digit0 && char_code_i <= Digit9) begin
      sextet = 6'(char_code_i + 8'd4);
    end else if (char_code_i == CharPlus) begin
      sextet = 6'd62;
    end else if (char_code_i == CharSlash) begin
      sextet = 6'd63;
    end else begin
      is_alpha = 1'b0;
    end
  end

  assign full_grp = !stopped_q && is_alpha && (cnt_q == 2'd3);
  assign take_new = !stopped_q && is_alpha && (cnt_q != 2'd3);
  // stop character flushes now, message end flushes whatever is left
  assign do_flush = (!stopped_q && !is_alpha) || (message_last_i && !full_grp);

  // group as it stands after this character
  always_comb begin
    ebuf = buf_q;
    ecnt = cnt_q;
    if (take_new) begin
      ebuf[cnt_q] = sextet;
      ecnt        = cnt_q + 2'd1;
    end
  end

  assign have_bytes = full_grp || (do_flush && ecnt >= 2'd2);

  always_comb begin
    job         = '0;
    job.msg_end = message_last_i;
    if (full_grp) begin
      job.data[0] = {buf_q[0], buf_q[1][5:4]};
      job.data[1] = {buf_q[1][3:0], buf_q[2][5:2]};
      job.data[2] = {buf_q[2][1:0], sextet};
      job.words   = 2'd3;
    end else if (have_bytes) begin
      job.data[0] = {ebuf[0], ebuf[1][5:4]};
      job.data[1] = {ebuf[1][3:0], ebuf[2][5:2]};
      job.words   = ecnt - 2'd1;
    end else begin
      job.no_data = 1'b1;
      job.words   = 2'd1;
    end
  end

  assign push_o     = accept && (have_bytes || message_last_i);
  assign push_job_o = job;

  always_comb begin
    cnt_d     = cnt_q;
    stopped_d = stopped_q;
    if (message_last_i || full_grp) begin
      cnt_d = 2'd0;
    end else if (take_new) begin
      cnt_d = ecnt;
    end else if (!stopped_q) begin
      cnt_d     = 2'd0;
      stopped_d = 1'b1;
    end
    if (message_last_i) begin
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 2'd0;
      stopped_q <= 1'b0;
    end else if (accept) begin
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && take_new) begin
      buf_q <= ebuf;
    end
  end

  `B64D_ASSERT(a_stop_clears_group, stopped_q |-> cnt_q == 2'd0)
  `B64D_ASSERT(a_msg_end_resets,
               accept && message_last_i |=> cnt_q == 2'd0 && !stopped_q)

endmodule

[hdl/b64d_fifo.sv]
// job queue between front end and output sequencer
`timescale 1ns / 1ps
`include "base64_stream_decoder_assert.svh"
module b64d_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output b64d_pkg::job_t head_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `B64D_ASSERT(a_fifo_bound, cnt_q <= CntW'(Depth))

endmodule

[hdl/b64d_back.sv]
// output sequencer: sends job words, one per ready cycle
`timescale 1ns / 1ps
`include "base64_stream_decoder_assert.svh"
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  b64d_pkg::job_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     data_byte_o,
  output logic           no_data_o,
  output logic           run_last_o,
  output logic           message_end_o
);
  import b64d_pkg::*;

  job_t       job_q;
  logic       busy_q, busy_d;
  logic [1:0] idx_q, idx_d;
  logic       last_word, out_accept;

  assign last_word  = (idx_q == job_q.words - 2'd1);
  assign out_accept = out_valid_o && out_ready_i;
  assign pop_o      = head_valid_i && (!busy_q || (out_accept && last_word));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (out_accept) begin
      if (last_word) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
  end

  assign out_valid_o   = busy_q;
  assign data_byte_o   = job_q.data[idx_q];
  assign no_data_o     = job_q.no_data;
  assign run_last_o    = last_word;
  assign message_end_o = last_word && job_q.msg_end;

  `B64D_ASSERT(a_marker_alone, out_valid_o && no_data_o |-> run_last_o && message_end_o)
  `B64D_ASSERT(a_idx_in_job, out_valid_o |-> idx_q < job_q.words)

endmodule
